>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules of the two-register step engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/trac_pkg.sv
// Package with types, codes and constants of the two-register step engine.
package trac_pkg;

	localparam int MEM_WORDS_DEF  = 256;
	localparam int CODE_WORDS_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int FUNC_W  = 5;
	localparam int ADDR_W  = 8;
	localparam int FIELD_W = 32;
	localparam int PC_W    = 7;
	localparam int TGT_W   = 6;
	localparam int STAT_W  = 2;

	localparam logic [FUNC_W-1:0] FN_LDA    = 5'd0;
	localparam logic [FUNC_W-1:0] FN_LDB    = 5'd1;
	localparam logic [FUNC_W-1:0] FN_STA    = 5'd2;
	localparam logic [FUNC_W-1:0] FN_STB    = 5'd3;
	localparam logic [FUNC_W-1:0] FN_A2B    = 5'd4;
	localparam logic [FUNC_W-1:0] FN_B2A    = 5'd5;
	localparam logic [FUNC_W-1:0] FN_ADDA_M = 5'd6;
	localparam logic [FUNC_W-1:0] FN_JMP    = 5'd22;
	localparam logic [FUNC_W-1:0] FN_JBZ    = 5'd23;
	localparam logic [FUNC_W-1:0] FN_JBNZ   = 5'd24;
	localparam logic [FUNC_W-1:0] FN_READ   = 5'd25;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 5'd26;

	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_SUB = 2'd1;
	localparam logic [1:0] ALU_AND = 2'd2;
	localparam logic [1:0] ALU_OR  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_END     = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [ADDR_W-1:0]         mem_address;
		logic signed [FIELD_W-1:0] immediate;
		logic [TGT_W-1:0]          jump_target;
	} step_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] reg_a_value;
		logic signed [FIELD_W-1:0] reg_b_value;
		logic [PC_W-1:0]           next_pc;
		logic signed [FIELD_W-1:0] read_value;
		logic [STAT_W-1:0]         status;
	} step_out_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic sweep;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic sweep_last;
	} dp_sts_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP
	} state_t;

endpackage

>>> rtl/core/trac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/trac_ctrl.sv
// Controller state machine of the two-register step engine.
`include "assert_macros.svh"

module trac_ctrl
	import trac_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     instr_valid,
	output logic     instr_ready,
	output logic     result_valid,
	input  logic     result_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t ctl
);

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	// Reset starts with a memory sweep so the data memory reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n     = state_q;
		ctl         = '0;
		instr_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				instr_ready = 1'b1;
				if (instr_valid) begin
					ctl.capture = 1'b1;
					state_n     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!out_valid_q || result_ready) begin
					ctl.commit = 1'b1;
					state_n    = sts.is_clear ? S_SWEEP : S_IDLE;
				end
			end
			S_SWEEP: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

	`ASSERT_NEXT(a_capture_exec, clk, arst_n, ctl.capture, state_q == S_EXEC, "capture not followed by execute")
	`ASSERT_NEXT(a_clear_sweep, clk, arst_n, ctl.commit && sts.is_clear, state_q == S_SWEEP && !instr_ready, "clear did not start a sweep")
	`ASSERT_NEXT(a_commit_valid, clk, arst_n, ctl.commit, result_valid, "committed result not presented")

endmodule

>>> rtl/core/trac_dp.sv
// Datapath of the two-register step engine: registers, ALU, data memory and sweep counter.
`include "assert_macros.svh"

module trac_dp
	import trac_pkg::*;
#(
	parameter int MEM_WORDS  = MEM_WORDS_DEF,
	parameter int CODE_WORDS = CODE_WORDS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  step_in_t        instr,
	input  logic            cfg_we,
	input  logic [PC_W-1:0] cfg_wdata,
	input  ctl_cmd_t        ctl,
	output dp_sts_t         sts,
	output step_out_t       result
);

	localparam int AW         = $clog2(MEM_WORDS);
	localparam int DW         = DATA_WIDTH;
	localparam int ADDR_SPAN  = 1 << ADDR_W;
	localparam int CW_W       = $clog2(CODE_WORDS + 1);
	localparam int LW         = (CW_W > PC_W) ? CW_W : PC_W;

	typedef logic [AW-1:0] addr_t;
	typedef addr_t [ADDR_SPAN-1:0] wrap_tab_t;

	// Address reduction modulo the memory depth, built by counting.
	function automatic wrap_tab_t build_wrap();
		wrap_tab_t tab;
		int        r;
		r = 0;
		for (int i = 0; i < ADDR_SPAN; i++) begin
			tab[i] = r[AW-1:0];
			r      = (r + 1 == MEM_WORDS) ? 0 : r + 1;
		end
		return tab;
	endfunction

	localparam wrap_tab_t WRAP_TAB = build_wrap();

	step_in_t        item_q;
	addr_t           wr_addr_q;
	addr_t           cnt_q;
	logic [DW-1:0]   a_q;
	logic [DW-1:0]   b_q;
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] plen_q;
	step_out_t       res_q;

	addr_t           rd_addr;
	logic [DW-1:0]   rdata;
	logic [DW+31:0]  imm_wide;
	logic [DW-1:0]   imm_dw;
	logic [LW-1:0]   len;
	logic [LW-1:0]   plen_ext;
	logic            exec_ok;

	logic [DW-1:0]   a_n;
	logic [DW-1:0]   b_n;
	logic [PC_W-1:0] pc_n;
	logic [DW-1:0]   rv_n;
	logic [STAT_W-1:0] st_n;
	logic            st_we;
	logic [DW-1:0]   st_wdata;
	logic [FUNC_W-1:0] k;
	logic [DW-1:0]   opnd;
	logic [DW-1:0]   alu_x;
	logic [DW-1:0]   alu_y;
	logic [DW+31:0]  a_wide;
	logic [DW+31:0]  b_wide;
	logic [DW+31:0]  rv_wide;

	logic            ram_we;
	addr_t           ram_waddr;
	logic [DW-1:0]   ram_wdata;

	assign rd_addr  = WRAP_TAB[instr.mem_address];
	assign imm_wide = {{DW{item_q.immediate[FIELD_W-1]}}, item_q.immediate};
	assign imm_dw   = imm_wide[DW-1:0];
	assign plen_ext = LW'(plen_q);
	assign len      = (plen_ext > LW'(CODE_WORDS)) ? LW'(CODE_WORDS) : plen_ext;
	assign exec_ok  = LW'(pc_q) < len;

	always_comb begin
		a_n      = a_q;
		b_n      = b_q;
		pc_n     = pc_q;
		rv_n     = '0;
		st_n     = ST_OK;
		st_we    = 1'b0;
		st_wdata = a_q;
		k        = item_q.func - FN_ADDA_M;
		opnd     = k[0] ? imm_dw : rdata;
		alu_x    = k[1] ? b_q : a_q;
		case (k[3:2])
			ALU_ADD: alu_y = alu_x + opnd;
			ALU_SUB: alu_y = alu_x - opnd;
			ALU_AND: alu_y = alu_x & opnd;
			default: alu_y = alu_x | opnd;
		endcase
		if (item_q.func <= FN_JBNZ) begin
			if (!exec_ok) begin
				st_n = ST_END;
			end else begin
				pc_n = pc_q + PC_W'(1);
				case (item_q.func)
					FN_LDA: a_n = imm_dw;
					FN_LDB: b_n = imm_dw;
					FN_STA: begin
						st_we    = 1'b1;
						st_wdata = a_q;
					end
					FN_STB: begin
						st_we    = 1'b1;
						st_wdata = b_q;
					end
					FN_A2B: b_n = a_q;
					FN_B2A: a_n = b_q;
					FN_JMP: pc_n = PC_W'(item_q.jump_target);
					FN_JBZ: begin
						if (b_q == '0) begin
							pc_n = PC_W'(item_q.jump_target);
						end
					end
					FN_JBNZ: begin
						if (b_q != '0) begin
							pc_n = PC_W'(item_q.jump_target);
						end
					end
					default: begin
						if (k[1]) begin
							b_n = alu_y;
						end else begin
							a_n = alu_y;
						end
					end
				endcase
			end
		end else if (item_q.func == FN_READ) begin
			rv_n = rdata;
		end else if (item_q.func == FN_CLEAR) begin
			a_n  = '0;
			b_n  = '0;
			pc_n = '0;
		end else begin
			st_n = ST_INVALID;
		end
	end

	assign a_wide  = {32'b0, a_n};
	assign b_wide  = {32'b0, b_n};
	assign rv_wide = {32'b0, rv_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			pc_q   <= '0;
			plen_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				plen_q <= cfg_wdata;
			end
			if (ctl.commit) begin
				a_q  <= a_n;
				b_q  <= b_n;
				pc_q <= pc_n;
			end
			if (ctl.sweep) begin
				cnt_q <= sts.sweep_last ? '0 : cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q    <= instr;
			wr_addr_q <= rd_addr;
		end
		if (ctl.commit) begin
			res_q.reg_a_value <= a_wide[FIELD_W-1:0];
			res_q.reg_b_value <= b_wide[FIELD_W-1:0];
			res_q.next_pc     <= pc_n;
			res_q.read_value  <= rv_wide[FIELD_W-1:0];
			res_q.status      <= st_n;
		end
	end

	assign ram_we    = ctl.sweep || (ctl.commit && st_we);
	assign ram_waddr = ctl.sweep ? cnt_q : wr_addr_q;
	assign ram_wdata = ctl.sweep ? '0 : st_wdata;

	trac_ram #(
		.WIDTH(DW),
		.DEPTH(MEM_WORDS)
	) u_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctl.capture),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign sts.is_clear   = item_q.func == FN_CLEAR;
	assign sts.sweep_last = cnt_q == AW'(MEM_WORDS - 1);
	assign result         = res_q;

	`ASSERT_NEXT(a_sweep_wrap, clk, arst_n, ctl.sweep && sts.sweep_last, cnt_q == '0, "sweep counter did not wrap")

endmodule

>>> rtl/core/two_register_accumulator_cpu_step_top.sv
// Top level of the two-register step engine: controller and datapath.
// This block executes one decoded instruction per transfer on the instr channel and returns
// one result per instruction on the result channel, in order. An ordinary instruction passes
// through the transfer cycle, which also reads the data memory word at mem_address, and
// an execute cycle, which uses the registered read data and writes the registers, the data
// memory and the result register; the next transfer is taken in the cycle after that. The
// execute cycle is set by the registered read port of the data memory. A finished result
// waits in its own register, so a new instruction is taken while the previous result is still
// waiting; an instruction whose result has nowhere to go holds in the execute cycle until the
// result register frees up. The clear function delivers its result and then zeroes the data
// memory one word per cycle, all MEM_WORDS words (256 by default), while no transfer is
// taken. The same sweep runs after reset before the first transfer.
// The program_length register is written through cfg_we and cfg_wdata in any cycle, with no
// wait, and should be changed only while the block is idle.
module two_register_accumulator_cpu_step_top
	import trac_pkg::*;
#(
	parameter int MEM_WORDS  = MEM_WORDS_DEF,
	parameter int CODE_WORDS = CODE_WORDS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            instr_valid,
	output logic            instr_ready,
	input  step_in_t        instr,
	output logic            result_valid,
	input  logic            result_ready,
	output step_out_t       result,
	input  logic            cfg_we,
	input  logic [PC_W-1:0] cfg_wdata
);

	// Commands from the controller and status from the datapath.
	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// The controller sequences capture, execute and the memory sweep.
	trac_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sts         (sts),
		.ctl         (ctl)
	);

	// The datapath holds A, B, the program counter, the length register and the memory.
	trac_dp #(
		.MEM_WORDS (MEM_WORDS),
		.CODE_WORDS(CODE_WORDS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.instr    (instr),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.ctl      (ctl),
		.sts      (sts),
		.result   (result)
	);

endmodule
